### rtl/core/sha_pkg.sv
// SHA-256 byte stream hasher: shared constants, types and round functions.
// No dependencies.
package sha_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned WinDep = 16;
  localparam int unsigned RamAw  = 4;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] r);
    word_t k;
    begin
      case (r)
        6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h;
    begin
      case (i)
        3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
        3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
        3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
        3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
    end
  endfunction

  function automatic word_t ror(input word_t v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic word_t sig0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

### rtl/core/sha_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/sha256_byte_stream_hash.sv
// SHA-256 over a byte stream: up to one byte per accepted item, digest on the last item.
// Depends on sha_pkg and sha_ram (schedule window memory).
// Throughput: one byte item per cycle while idle; the 64th byte of a block starts a
// compression (S_RD and S_RND per round, from round 16 with tap captures; then S_ADD).
// The last item pads one byte per cycle, writes the length in S_LEN, S_LEN2, runs one or
// two compressions, hands out 8 digest items; reset (rst_n low, synchronous) reloads H.
module sha256_byte_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [8] has_byte
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_number
  output logic        out_tlast   // last_word
);
  localparam int unsigned Aw = sha_pkg::RamAw;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_PAD   = 8'b00000010,
    S_RD    = 8'b00000100,
    S_RND   = 8'b00001000,
    S_ADD   = 8'b00010000,
    S_OUT   = 8'b00100000,
    S_LEN   = 8'b01000000,
    S_LEN2  = 8'b10000000
  } st_t;

  st_t st_r, st_nxt;
  logic [5:0]  pos_r;
  logic [63:0] len_r;
  logic [5:0]  rnd_r;
  logic [1:0]  sub_r;    // schedule tap step during a round
  logic        fin_r;    // message end in progress
  logic        two_r;    // padding goes on in a further block
  logic [2:0]  onum_r;
  sha_pkg::word_t h_r [8];
  sha_pkg::word_t v_r [8];
  sha_pkg::word_t cur_r;  // word being built from bytes / padding
  sha_pkg::word_t t15_r, t7_r, t2_r;

  logic          we;
  logic [Aw-1:0] waddr, raddr;
  sha_pkg::word_t wdata, rdata;

  sha_ram #(.Width(sha_pkg::WordW), .Depth(sha_pkg::WinDep)) u_win (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic acc;
  logic [7:0] nb;
  logic [1:0] tap;
  sha_pkg::word_t cur_new, wt, t1, t2, s1e, che, s0a, maj;

  assign in_tready = (st_r == S_IDLE);
  assign acc = in_tvalid && in_tready;
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata = {5'd0, onum_r, h_r[onum_r]};
  assign out_tlast = (onum_r == 3'd7);

  // byte placed in cur word; padding uses 0x80 at the message end, then zeros
  always_comb begin
    nb = (st_r == S_IDLE) ? in_tdata[7:0] : ((pos_r == len_r[8:3]) ? 8'h80 : 8'h00);
    cur_new = cur_r;
    case (pos_r[1:0])
      2'd0: cur_new = {nb, 24'd0};
      2'd1: cur_new[23:16] = nb;
      2'd2: cur_new[15:8] = nb;
      default: cur_new[7:0] = nb;
    endcase
  end

  // round taps: sub 0 uses w[r-15], 1 w[r-7], 2 w[r-2], 3 w[r];
  // the read address runs one step ahead of the tap being captured
  assign tap = (st_r == S_RND) ? sub_r + 2'd1 : sub_r;

  always_comb begin
    case (tap)
      2'd0: raddr = Aw'(rnd_r - 6'd15);
      2'd1: raddr = Aw'(rnd_r - 6'd7);
      2'd2: raddr = Aw'(rnd_r - 6'd2);
      default: raddr = Aw'(rnd_r);
    endcase
  end

  assign wt = (rnd_r < 6'd16) ? rdata
            : rdata + sha_pkg::sig0(t15_r) + t7_r + sha_pkg::sig1(t2_r);
  assign s1e = sha_pkg::ror(v_r[4], 6) ^ sha_pkg::ror(v_r[4], 11) ^ sha_pkg::ror(v_r[4], 25);
  assign che = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign s0a = sha_pkg::ror(v_r[0], 2) ^ sha_pkg::ror(v_r[0], 13) ^ sha_pkg::ror(v_r[0], 22);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1 = v_r[7] + s1e + che + sha_pkg::round_k(rnd_r) + wt;
  assign t2 = s0a + maj;

  always_comb begin
    we = 1'b0;
    waddr = Aw'(pos_r[5:2]);
    wdata = cur_new;
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (acc && in_tdata[8] && pos_r[1:0] == 2'd3) we = 1'b1;
        if (acc && in_tdata[8] && pos_r == 6'd63) st_nxt = S_RD;
        else if (acc && in_tlast) st_nxt = S_PAD;
      end
      S_PAD: begin
        if (pos_r[1:0] == 2'd3) we = 1'b1;
        if (pos_r == 6'd63) st_nxt = S_RD;
        if (pos_r == 6'd55) st_nxt = S_LEN;
      end
      S_LEN: begin
        we = 1'b1; waddr = Aw'(4'd14); wdata = len_r[63:32]; st_nxt = S_LEN2;
      end
      S_LEN2: begin
        we = 1'b1; waddr = Aw'(4'd15); wdata = len_r[31:0]; st_nxt = S_RD;
      end
      S_RD: st_nxt = S_RND;
      S_RND: begin
        if (sub_r == 2'd3) begin
          if (rnd_r >= 6'd16) begin
            we = 1'b1; waddr = Aw'(rnd_r); wdata = wt;
          end
          if (rnd_r == 6'd63) st_nxt = S_ADD;
          else st_nxt = S_RD;
        end
      end
      S_ADD: st_nxt = !fin_r ? S_IDLE : (two_r ? S_PAD : S_OUT);
      S_OUT: if (out_tready && onum_r == 3'd7) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pos_r <= '0; len_r <= '0; rnd_r <= '0; sub_r <= '0;
      fin_r <= 1'b0; two_r <= 1'b0; onum_r <= '0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= sha_pkg::init_h(3'(i));
        v_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      case (st_r)
        S_IDLE: begin
          if (acc) begin
            if (in_tdata[8]) begin
              cur_r <= cur_new;
              pos_r <= pos_r + 6'd1;
              len_r <= len_r + 64'd8;
            end
            fin_r <= in_tlast;
            // a full block that ends the message still needs a padding block
            two_r <= in_tdata[8] && in_tlast && pos_r == 6'd63;
            if (in_tdata[8] && pos_r == 6'd63) begin
              sub_r <= 2'd3;
              for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
            end
          end
        end
        S_PAD: begin
          cur_r <= cur_new;
          pos_r <= pos_r + 6'd1;
          if (st_nxt == S_RD) begin
            two_r <= 1'b1;
            sub_r <= 2'd3;
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          end
        end
        S_LEN2: begin
          two_r <= 1'b0;
          sub_r <= 2'd3;
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        end
        S_RND: begin
          case (sub_r)
            2'd0: t15_r <= rdata;
            2'd1: t7_r <= rdata;
            2'd2: t2_r <= rdata;
            default: begin
              v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
              v_r[4] <= v_r[3] + t1; v_r[3] <= v_r[2]; v_r[2] <= v_r[1];
              v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
              rnd_r <= rnd_r + 6'd1;
            end
          endcase
          if (sub_r == 2'd3) sub_r <= (rnd_r + 6'd1 >= 6'd16) ? 2'd0 : 2'd3;
          else sub_r <= sub_r + 2'd1;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          rnd_r <= '0;
          onum_r <= '0;
          // second padding block restarts at word 0 (0x80 first if the message filled its block, else zeros)
          if (fin_r && two_r) pos_r <= 6'd0;
        end
        S_OUT: begin
          if (out_tready) begin
            onum_r <= onum_r + 3'd1;
            if (onum_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::init_h(3'(i));
              pos_r <= '0; len_r <= '0; fin_r <= 1'b0; two_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### bench/sha256_digest_checker.sv
// Digest checker for the SHA-256 byte stream hasher: watches both stream
// channels, computes expected digest words and compares. Depends on sha_pkg.
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_words
);
  typedef struct packed {
    sha_pkg::word_t digest_word;
    logic [2:0]     word_number;
    logic           last_word;
  } digest_item_t;

  localparam sha_pkg::word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam sha_pkg::word_t H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  sha_pkg::word_t chain [8];
  sha_pkg::word_t blk [16];
  logic [5:0]     fill_pos;
  logic [63:0]    bit_len;
  digest_item_t   digest_q[$];

  function automatic sha_pkg::word_t rotr(sha_pkg::word_t v, int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  task automatic run_block();
    sha_pkg::word_t w [16];
    sha_pkg::word_t v [8];
    sha_pkg::word_t wt, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wt = w[r];
      end else begin
        wt = w[r%16] + w[(r-7)%16]
           + (rotr(w[(r-15)%16], 7) ^ rotr(w[(r-15)%16], 18) ^ (w[(r-15)%16] >> 3))
           + (rotr(w[(r-2)%16], 17) ^ rotr(w[(r-2)%16], 19) ^ (w[(r-2)%16] >> 10));
        w[r%16] = wt;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + wt;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic place_byte(int pos, logic [7:0] b);
    blk[pos/4][8*(3-pos%4) +: 8] = b;
  endtask

  task automatic absorb_item(logic [7:0] b, logic has, logic fin);
    digest_item_t it;
    int p;
    if (has) begin
      place_byte(fill_pos, b);
      bit_len += 64'd8;
      fill_pos++;
      if (fill_pos == 0) run_block();
    end
    if (fin) begin
      p = fill_pos;
      place_byte(p, 8'h80);
      for (int i = p + 1; i < 64; i++) place_byte(i, 8'h00);
      if (p >= 56) begin
        run_block();
        for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      blk[14] = bit_len[63:32];
      blk[15] = bit_len[31:0];
      run_block();
      for (int i = 0; i < 8; i++) begin
        it.digest_word = chain[i];
        it.word_number = i[2:0];
        it.last_word   = (i == 7);
        digest_q = {digest_q, it};
      end
      for (int i = 0; i < 8; i++) chain[i] = H_INIT[i];
      fill_pos = '0;
      bit_len  = '0;
    end
  endtask

  always @(posedge clk) begin
    digest_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) chain[i] = H_INIT[i];
      for (int i = 0; i < 16; i++) blk[i] = '0;
      fill_pos = '0;
      bit_len  = '0;
      digest_q.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready)
        absorb_item(in_tdata[7:0], in_tdata[8], in_tlast);
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected digest item %h last %b", out_tdata, out_tlast);
        end else begin
          want = digest_q.pop_front();
          if (out_tdata[31:0] !== want.digest_word || out_tdata[34:32] !== want.word_number
              || out_tlast !== want.last_word) begin
            fail_count++;
            if (fail_count <= 10)
              $display("digest mismatch: want word %0d %h last %b, got word %0d %h last %b",
                       want.word_number, want.digest_word, want.last_word,
                       out_tdata[34:32], out_tdata[31:0], out_tlast);
          end
        end
      end
    end
    pending_words = digest_q.size();
  end
endmodule

### bench/sha256_byte_stream_hash_test.sv
// Testbench top for sha256_byte_stream_hash: drives byte messages with random
// gaps and back-pressure; sha256_digest_checker does the checking.
module sha256_byte_stream_hash_test;
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          pending_words;
  int          idle_cycles;
  int          sent_items;
  bit          hold_sink;

  localparam int IdleLimit = 20000;

  sha256_byte_stream_hash dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast);

  sha256_digest_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .fail_count, .pending_words);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one item, hold until accepted, then, if gaps is set, pause a random gap.
  task automatic send_item(logic [7:0] b, logic has, logic fin, bit gaps);
    int g;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, has, b};
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom) & 16'h01ff;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send_message(int n, bit gaps, bit end_has);
    for (int i = 0; i < n; i++)
      send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, gaps);
    send_item(8'($urandom_range(0, 255)), end_has, 1'b1, gaps);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
  endtask

  // Sink: random stalls, plus one long hold while the source keeps sending.
  initial begin
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_sink && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (gap_len()) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int n;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    hold_sink   = 1'b0;
    sent_items  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty message, byte with end, extreme bytes, pad boundaries.
    send_item(8'h00, 1'b0, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0, 1'b0);
    send_item(8'ha5, 1'b1, 1'b0, 1'b0);
    send_item(8'h3c, 1'b0, 1'b1, 1'b0);
    drain();
    send_message(54, 1'b0, 1'b1);
    send_message(55, 1'b1, 1'b1);
    send_message(56, 1'b1, 1'b0);
    send_message(63, 1'b0, 1'b1);
    send_message(64, 1'b1, 1'b0);
    drain();

    // Long sink hold while many short messages pile up.
    hold_sink = 1'b1;
    for (int m = 0; m < 12; m++)
      send_message($urandom_range(0, 3), 1'b0, 1'($urandom_range(0, 1)));
    drain();

    // Random messages: mostly short, a few past a block boundary.
    while (sent_items < 360) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
      for (int i = 0; i < n; i++)
        send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) != 0), 1'b0, 1'b1);
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 1'b1);
    end
    drain();
    repeat (300) @(negedge clk);

    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
